// ===== rtl/isa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// isa_pkg
// Shared types and codes for the indexed scatter-add block: operation codes,
// status codes, register map and the result bundle.
// ----------------------------------------------------------------------------
package isa_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned FUNC_W = 2;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned ROW_W  = 10;
  localparam int unsigned COL_W  = 4;
  localparam int unsigned RW_W   = 5;

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ACCUM = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_REJECT = 2'd1;
  localparam logic [STAT_W-1:0] ST_SAT    = 2'd2;

  // register map (word index)
  localparam logic REG_ROW_WIDTH = 1'b0;
  localparam logic [RW_W-1:0] ROW_WIDTH_RST = 5'd16;

  // one result beat
  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] value;
    logic [STAT_W-1:0] status;
  } isa_result_t;

endpackage
`default_nettype wire

// ===== rtl/isa_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// isa_ram
// Generic single-write, single-read synchronous RAM with a registered read.
// A read at the address being written returns the old content.
// ----------------------------------------------------------------------------
module isa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16384,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/isa_pipe.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// isa_pipe
// Read-modify-write datapath: address and range check at accept, RAM read,
// then add with saturation and write back, with forwarding of the previous
// write so that beats to the same entry may follow each other directly.
// ----------------------------------------------------------------------------
module isa_pipe
  import isa_pkg::*;
#(
  parameter int unsigned MAX_ROWS = 1024,
  parameter int unsigned MAX_COLS = 16,
  localparam int unsigned DEPTH   = MAX_ROWS * MAX_COLS,
  localparam int unsigned AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire logic [FUNC_W-1:0] func_i,
  input  wire logic [ROW_W-1:0]  dst_row_i,
  input  wire logic [COL_W-1:0]  col_i,
  input  wire logic [DATA_W-1:0] value_i,
  input  wire logic [RW_W-1:0]   row_width_i,
  // ram read side
  output logic                   rd_en_o,
  output logic      [AW-1:0]     rd_addr_o,
  input  wire logic [DATA_W-1:0] rd_data_i,
  // ram write side
  output logic                   wr_en_o,
  output logic      [AW-1:0]     wr_addr_o,
  output logic      [DATA_W-1:0] wr_data_o,
  // result
  output isa_result_t            result_o
);

  localparam int unsigned PW = ROW_W + $clog2(MAX_COLS + 1) + 1;

  // accept stage: range check and linear address
  logic          reject;
  logic [PW-1:0] row_offs;
  logic [PW-1:0] lin_addr;

  assign reject = ({1'b0, col_i} >= row_width_i) ||
                  (32'(col_i) >= 32'(MAX_COLS)) ||
                  (32'(dst_row_i) >= 32'(MAX_ROWS));
  assign row_offs = PW'(dst_row_i) * PW'(MAX_COLS);
  assign lin_addr = row_offs + PW'(col_i);

  assign rd_en_o   = accept_i && !reject;
  assign rd_addr_o = AW'(lin_addr);

  // stage 1 registers
  logic              s1_vld_q;
  logic              s1_rej_q;
  logic [FUNC_W-1:0] s1_func_q;
  logic [AW-1:0]     s1_addr_q;
  logic [DATA_W-1:0] s1_val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_rej_q  <= reject;
      s1_func_q <= func_i;
      s1_addr_q <= AW'(lin_addr);
      s1_val_q  <= value_i;
    end
  end

  // forwarding of the write made at the previous edge
  logic              lw_vld_q;
  logic [AW-1:0]     lw_addr_q;
  logic [DATA_W-1:0] lw_data_q;
  logic [DATA_W-1:0] old_val;

  assign old_val = (lw_vld_q && (lw_addr_q == s1_addr_q)) ? lw_data_q : rd_data_i;

  // add with saturation
  logic [DATA_W:0]   sum;
  logic              ovf;
  logic [DATA_W-1:0] sat_val;

  assign sum = {old_val[DATA_W-1], old_val} + {s1_val_q[DATA_W-1], s1_val_q};
  assign ovf = sum[DATA_W] != sum[DATA_W-1];
  assign sat_val = !ovf ? sum[DATA_W-1:0] :
                   (sum[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}});

  // operation select
  logic              wr_en;
  logic [DATA_W-1:0] new_val;
  logic [STAT_W-1:0] new_stat;

  always_comb begin
    wr_en    = 1'b0;
    new_val  = old_val;
    new_stat = ST_OK;
    if (s1_rej_q) begin
      new_val  = '0;
      new_stat = ST_REJECT;
    end else begin
      case (s1_func_q)
        FUNC_WRITE: begin
          wr_en   = s1_vld_q;
          new_val = s1_val_q;
        end
        FUNC_ACCUM: begin
          wr_en    = s1_vld_q;
          new_val  = sat_val;
          new_stat = ovf ? ST_SAT : ST_OK;
        end
        default: begin
          new_val = old_val;
        end
      endcase
    end
  end

  assign wr_en_o   = wr_en;
  assign wr_addr_o = s1_addr_q;
  assign wr_data_o = new_val;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lw_vld_q <= 1'b0;
    end else begin
      lw_vld_q <= wr_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      lw_addr_q <= s1_addr_q;
      lw_data_q <= new_val;
    end
  end

  // result register
  logic              res_vld_q;
  logic [DATA_W-1:0] res_val_q;
  logic [STAT_W-1:0] res_stat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      res_val_q  <= new_val;
      res_stat_q <= new_stat;
    end
  end

  assign result_o.valid  = res_vld_q;
  assign result_o.value  = res_val_q;
  assign result_o.status = res_stat_q;

endmodule
`default_nettype wire

// ===== rtl/indexed_scatter_add.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_scatter_add
// Scatter-add into a MAX_ROWS x MAX_COLS table of signed Q16.16 accumulators
// held in one RAM; write, accumulate (saturating) or read one entry per beat.
// ----------------------------------------------------------------------------
// One command beat is taken per clock while busy is low; each beat yields its
// result beat on result_valid_o, for one cycle, after the stage 1 and result
// registers of isa_pipe, and the receiver cannot stall it. The rate is set by
// the single RAM read port and the read-add-write loop, which forwards the
// previous write so back-to-back beats to the same entry are correct. After
// reset the table is zeroed by a clearing pass over all MAX_ROWS*MAX_COLS
// entries (16384 at the defaults), during which busy is high; register writes
// are taken always.
module indexed_scatter_add
  import isa_pkg::*;
#(
  parameter int unsigned MAX_ROWS = 1024,
  parameter int unsigned MAX_COLS = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // command channel
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [FUNC_W-1:0] func_i,
  input  wire logic [ROW_W-1:0]  dst_row_i,
  input  wire logic [COL_W-1:0]  col_i,
  input  wire logic [DATA_W-1:0] value_i,
  // result channel
  output logic                   result_valid_o,
  output logic      [DATA_W-1:0] read_value_o,
  output logic      [STAT_W-1:0] status_o,
  // register port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready
);

  localparam int unsigned DEPTH = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // register port
  logic [RW_W-1:0] row_width_q;
  logic            reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2] == REG_ROW_WIDTH;
  assign prdata  = reg_sel ? {{(32-RW_W){1'b0}}, row_width_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q <= ROW_WIDTH_RST;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      row_width_q <= pwdata[RW_W-1:0];
    end
  end

  // clearing pass after reset
  logic          clr_act_q;
  logic [AW-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_act_q <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_act_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == AW'(DEPTH - 1)) begin
        clr_act_q <= 1'b0;
      end
    end
  end

  assign busy = clr_act_q;

  // datapath
  logic              accept;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [DATA_W-1:0] rd_data;
  logic              pipe_we;
  logic [AW-1:0]     pipe_waddr;
  logic [DATA_W-1:0] pipe_wdata;
  isa_result_t       result;

  assign accept = start && !busy;

  isa_pipe #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .func_i      (func_i),
    .dst_row_i   (dst_row_i),
    .col_i       (col_i),
    .value_i     (value_i),
    .row_width_i (row_width_q),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .wr_en_o     (pipe_we),
    .wr_addr_o   (pipe_waddr),
    .wr_data_o   (pipe_wdata),
    .result_o    (result)
  );

  // write port shared between clearing pass and datapath
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_wdata;

  assign ram_we    = clr_act_q || pipe_we;
  assign ram_waddr = clr_act_q ? clr_cnt_q : pipe_waddr;
  assign ram_wdata = clr_act_q ? '0 : pipe_wdata;

  isa_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  assign result_valid_o = result.valid;
  assign read_value_o   = result.value;
  assign status_o       = result.status;

endmodule
`default_nettype wire

// ===== test/scatter_add_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// scatter_add_checker
// Watches the command, result and register channels of indexed_scatter_add,
// keeps its own copy of the accumulator table and row width, predicts one
// result per accepted command and compares it with each result beat in order.
// ----------------------------------------------------------------------------
module scatter_add_checker
  import isa_pkg::*;
#(
  parameter int unsigned MAX_ROWS = 1024,
  parameter int unsigned MAX_COLS = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic              busy_i,
  input  wire logic [FUNC_W-1:0] func_i,
  input  wire logic [ROW_W-1:0]  dst_row_i,
  input  wire logic [COL_W-1:0]  col_i,
  input  wire logic [DATA_W-1:0] value_i,
  input  wire logic              result_valid_i,
  input  wire logic [DATA_W-1:0] read_value_i,
  input  wire logic [STAT_W-1:0] status_i,
  input  wire logic              psel_i,
  input  wire logic              penable_i,
  input  wire logic              pwrite_i,
  input  wire logic [2:0]        paddr_i,
  input  wire logic [31:0]       pwdata_i,
  input  wire logic              pready_i,
  output int                     fail_count_o,
  output int                     pending_o
);

  localparam logic [2:0] ROW_WIDTH_ADDR = 3'(REG_ROW_WIDTH) << 2;
  localparam int unsigned TABLE_DEPTH = MAX_ROWS * MAX_COLS;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic [STAT_W-1:0] status;
  } entry_result_t;

  logic [DATA_W-1:0] table_copy [TABLE_DEPTH];
  logic [RW_W-1:0]   width_copy;
  entry_result_t     due_results [$];
  int                mismatches;

  assign fail_count_o = mismatches;
  assign pending_o    = due_results.size();

  // apply one command to the table copy and return the entry after it
  function automatic entry_result_t apply_command(
    input logic [FUNC_W-1:0] op,
    input logic [ROW_W-1:0]  row,
    input logic [COL_W-1:0]  col,
    input logic [DATA_W-1:0] operand
  );
    entry_result_t     res;
    int unsigned       cols_used;
    int unsigned       slot;
    logic [DATA_W:0]   sum;
    cols_used = (width_copy > MAX_COLS) ? MAX_COLS : width_copy;
    res.status = ST_OK;
    // rejected address leaves the table alone
    if (col >= cols_used || row >= MAX_ROWS) begin
      res.value  = '0;
      res.status = ST_REJECT;
      return res;
    end
    slot = row * MAX_COLS + col;
    if (op == FUNC_WRITE) begin
      table_copy[slot] = operand;
    end else if (op == FUNC_ACCUM) begin
      sum = {table_copy[slot][DATA_W-1], table_copy[slot]} +
            {operand[DATA_W-1], operand};
      // clamp when the 33-bit sum no longer fits in 32 bits
      if (sum[DATA_W] != sum[DATA_W-1]) begin
        sum[DATA_W-1:0] = sum[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}}
                                      : {1'b0, {(DATA_W-1){1'b1}}};
        res.status = ST_SAT;
      end
      table_copy[slot] = sum[DATA_W-1:0];
    end
    res.value = table_copy[slot];
    return res;
  endfunction

  // compare result beats, predict for the command beat at this edge, then
  // take a register write made at the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    entry_result_t want;
    if (!rst_ni) begin
      foreach (table_copy[i]) table_copy[i] = '0;
      width_copy = ROW_WIDTH_RST;
      due_results.delete();
      mismatches = 0;
    end else begin
      if (result_valid_i) begin
        if (due_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result beat with nothing due: value %h status %0d",
                     $realtime, read_value_i, status_i);
        end else begin
          want = due_results.pop_front();
          if (want.value !== read_value_i || want.status !== status_i) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch: expected value %h status %0d, got value %h status %0d",
                       $realtime, want.value, want.status, read_value_i, status_i);
          end
        end
      end
      if (start_i && !busy_i)
        due_results.push_back(apply_command(func_i, dst_row_i, col_i, value_i));
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == ROW_WIDTH_ADDR)
        width_copy = pwdata_i[RW_W-1:0];
    end
  end

endmodule
`default_nettype wire

// ===== test/indexed_scatter_add_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_scatter_add_tb
// Drives command beats and row width writes into indexed_scatter_add: a short
// directed set of edge cases, then random phases over several row widths with
// random gaps. The checker predicts and compares; this top gives the verdict.
// ----------------------------------------------------------------------------
module indexed_scatter_add_tb;
  import isa_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
  localparam logic [2:0] ROW_WIDTH_ADDR = 3'(REG_ROW_WIDTH) << 2;
  localparam int IDLE_LIMIT = 100000;
  localparam int ITEMS_PER_PHASE = 300;
  localparam logic [DATA_W-1:0] POS_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] NEG_MAX = 32'h8000_0000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [FUNC_W-1:0] func_i = FUNC_READ;
  logic [ROW_W-1:0]  dst_row_i = '0;
  logic [COL_W-1:0]  col_i = '0;
  logic [DATA_W-1:0] value_i = '0;
  logic              result_valid_o;
  logic [DATA_W-1:0] read_value_o;
  logic [STAT_W-1:0] status_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  int                fail_count;
  int                pending;
  int                idle_cycles = 0;

  indexed_scatter_add dut (
    .clk_i, .rst_ni, .start, .busy, .func_i, .dst_row_i, .col_i, .value_i,
    .result_valid_o, .read_value_o, .status_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  scatter_add_checker checker_i (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .func_i, .dst_row_i,
    .col_i, .value_i, .result_valid_i(result_valid_o),
    .read_value_i(read_value_o), .status_i(status_o),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .pready_i(pready),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // clock
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // watchdog on cycles without any accepted beat, result beat or register access
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o || (psel && penable && pready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // one command beat, held until taken
  task automatic send_command(input logic [FUNC_W-1:0] op, input logic [ROW_W-1:0] row,
                              input logic [COL_W-1:0] col, input logic [DATA_W-1:0] val);
    start     <= 1'b1;
    func_i    <= op;
    dst_row_i <= row;
    col_i     <= col;
    value_i   <= val;
    do @(posedge clk_i); while (busy);
  endtask

  // drop start for a number of cycles
  task automatic pause(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // mostly back to back, sometimes short, rarely long
  function automatic int gap_length();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) return 0;
    if (sel < 88) return $urandom_range(1, 3);
    if (sel < 98) return $urandom_range(4, 20);
    return $urandom_range(30, 150);
  endfunction

  // wait for every due result, then let the pipeline settle
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // register write: setup then access
  task automatic write_row_width(input logic [RW_W-1:0] width);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ROW_WIDTH_ADDR;
    pwdata  <= 32'(width);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 35) return $urandom();
    if (sel < 70) return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
    if (sel < 80) return POS_MAX - $urandom_range(0, 3);
    if (sel < 90) return NEG_MAX + $urandom_range(0, 3);
    if (sel < 95) return '0;
    return '1;
  endfunction

  // a few hot rows at both ends of the table so entries build up
  function automatic logic [ROW_W-1:0] pick_row();
    int unsigned r;
    if ($urandom_range(0, 99) < 70) begin
      r = $urandom_range(0, 7);
      return (r < 4) ? ROW_W'(r) : ROW_W'(1016 + r);
    end
    return ROW_W'($urandom());
  endfunction

  function automatic logic [FUNC_W-1:0] pick_op();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 25) return FUNC_WRITE;
    if (sel < 70) return FUNC_ACCUM;
    if (sel < 94) return FUNC_READ;
    return FUNC_SPARE;
  endfunction

  task automatic random_phase(input int count);
    for (int i = 0; i < count; i++) begin
      send_command(pick_op(), pick_row(), COL_W'($urandom()), pick_value());
      pause(gap_length());
    end
  endtask

  initial begin
    logic [RW_W-1:0] widths [6];
    widths = '{5'd0, 5'd1, 5'd31, 5'd7, 5'd16, 5'd17};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset width, table extremes, saturation both ways
    send_command(FUNC_READ, 10'd1023, 4'd15, '0);
    send_command(FUNC_WRITE, 10'd1023, 4'd15, POS_MAX);
    send_command(FUNC_ACCUM, 10'd1023, 4'd15, 32'd1);
    send_command(FUNC_ACCUM, 10'd1023, 4'd15, NEG_MAX);
    send_command(FUNC_ACCUM, 10'd1023, 4'd15, NEG_MAX);
    send_command(FUNC_READ, 10'd1023, 4'd15, '1);
    send_command(FUNC_WRITE, 10'd0, 4'd0, NEG_MAX);
    send_command(FUNC_ACCUM, 10'd0, 4'd0, '1);
    send_command(FUNC_ACCUM, 10'd0, 4'd0, POS_MAX);
    send_command(FUNC_SPARE, 10'd0, 4'd0, 32'h1234_5678);
    send_command(FUNC_ACCUM, 10'd5, 4'd3, 32'h0001_8000);
    pause(3);
    send_command(FUNC_ACCUM, 10'd5, 4'd3, 32'hFFFF_4000);
    send_command(FUNC_READ, 10'd5, 4'd3, '0);
    drain();

    // directed: width zero rejects everything, wide setting acts as full row
    write_row_width(5'd0);
    send_command(FUNC_WRITE, 10'd0, 4'd0, POS_MAX);
    send_command(FUNC_ACCUM, 10'd1023, 4'd15, 32'd1);
    drain();
    write_row_width(5'd31);
    send_command(FUNC_ACCUM, 10'd1023, 4'd15, 32'd5);
    send_command(FUNC_READ, 10'd0, 4'd0, '0);
    drain();
    write_row_width(5'd1);
    send_command(FUNC_WRITE, 10'd2, 4'd1, 32'd9);
    send_command(FUNC_ACCUM, 10'd2, 4'd0, 32'd9);
    drain();

    // random phases over several widths, the extremes included
    foreach (widths[k]) begin
      write_row_width(widths[k]);
      random_phase(ITEMS_PER_PHASE / 2);
      drain();
    end
    write_row_width(RW_W'($urandom_range(2, 15)));
    random_phase(ITEMS_PER_PHASE);
    drain();
    write_row_width(5'd16);
    random_phase(ITEMS_PER_PHASE);
    drain();
    repeat (10) @(posedge clk_i);

    if (fail_count == 0 && pending == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
`default_nettype wire
